[hw/rtl/bfdh_pkg.sv]
// Shared constants and control structs for the double-hash Bloom filter.
package bfdh_pkg;

  localparam int HASH_W = 64;
  localparam logic [HASH_W-1:0] DJB2_SEED = 64'd5381;

  localparam int DEF_MAX_BYTES  = 4096;
  localparam int DEF_MAX_HASHES = 16;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_sts_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctl_t;

endpackage

[hw/rtl/bfdh_hash.sv]
// Running djb2 and sdbm key hashes, one key byte per accepted request.
module bfdh_hash (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic [7:0]                 key_byte,
  input  logic                       last_byte,
  output logic [bfdh_pkg::HASH_W-1:0] djb2_val,
  output logic [bfdh_pkg::HASH_W-1:0] sdbm_val
);
  import bfdh_pkg::*;

  logic [HASH_W-1:0] djb2_r;
  logic [HASH_W-1:0] sdbm_r;
  logic [HASH_W-1:0] byte_ext;

  assign byte_ext = {{(HASH_W-8){1'b0}}, key_byte};

  // hash values including the byte now presented
  assign djb2_val = (djb2_r << 5) + djb2_r + byte_ext;
  assign sdbm_val = byte_ext + (sdbm_r << 6) + (sdbm_r << 16) - sdbm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      djb2_r <= DJB2_SEED;
      sdbm_r <= '0;
    end else if (in_fire) begin
      if (last_byte) begin
        djb2_r <= DJB2_SEED;
        sdbm_r <= '0;
      end else begin
        djb2_r <= djb2_val;
        sdbm_r <= sdbm_val;
      end
    end
  end

endmodule

[hw/rtl/bfdh_mod.sv]
// Bit-serial remainder of a 64-bit hash by the store modulus, one bit per cycle.
module bfdh_mod #(
  parameter int MW = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bfdh_pkg::HASH_W-1:0] value,
  input  logic [MW-1:0]              modulus,
  output bfdh_pkg::mod_sts_t         sts,
  output logic [MW-1:0]              result
);
  import bfdh_pkg::*;

  localparam int CW = $clog2(HASH_W);

  logic [HASH_W-1:0] val_r;
  logic [MW-1:0]     rem_r;
  logic [MW-1:0]     m_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [MW:0]       shifted;
  logic [MW-1:0]     rem_nxt;

  // rem < m holds, so one compare and subtract keeps it reduced
  assign shifted = {rem_r, val_r[HASH_W-1]};
  assign rem_nxt = (shifted >= {1'b0, m_r}) ? MW'(shifted - {1'b0, m_r}) : MW'(shifted);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(HASH_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= value;
      m_r   <= modulus;
      rem_r <= '0;
    end else if (busy_r) begin
      val_r <= val_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = rem_r;

endmodule

[hw/rtl/bfdh_store.sv]
// Filter bit store: one-port byte memory with registered read and a clear sweep.
module bfdh_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bfdh_pkg::store_ctl_t ctl,
  input  logic [AW-1:0]        addr,
  input  logic [7:0]           wdata,
  output logic [7:0]           rdata,
  output logic                 clear_busy
);
  import bfdh_pkg::*;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_r;
  logic [AW-1:0] clr_cnt_r;
  logic          clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(DEPTH - 1)) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) rdata_r <= mem[addr];
  end

  assign rdata      = rdata_r;
  assign clear_busy = clr_busy_r;

endmodule

[hw/rtl/bloom_filter_double_hash.sv]
// Bloom filter with djb2/sdbm double hashing. A key comes in one byte per
// request and every byte that is not the last leaves the block idle for the
// next one. On the last byte three bit-serial units reduce djb2, sdbm and
// 2^64-1 modulo 8*filter_bytes; the third one lets the position walk correct
// for the 64-bit wrap of djb2 + i*sdbm + i*i. The block then walks the
// num_hashes positions through the single-port bit store: a read and a check
// state per position to test, and for an insert a second pass with a read
// and a write state per position to read, modify and write back, then a done
// state to hand the result over. The next byte after a final byte is thus
// taken only back in idle, and later while the previous result still waits on
// out_stall; in_stall stays high meanwhile. After reset the store clears all
// MAX_BYTES bytes, and the first byte is taken only once the clear is done.
// The result register frees the input side: bytes of the next key are taken
// while a result still waits on out_stall.
module bloom_filter_double_hash #(
  parameter int MAX_BYTES  = bfdh_pkg::DEF_MAX_BYTES,
  parameter int MAX_HASHES = bfdh_pkg::DEF_MAX_HASHES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_key_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_was_present,
  output logic        out_is_query,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bfdh_pkg::*;

  localparam int AW  = $clog2(MAX_BYTES);
  localparam int NBW = $clog2(MAX_BYTES + 1);
  localparam int MW  = NBW + 3;
  localparam int HW  = $clog2(MAX_HASHES + 1);

  localparam logic REG_FILTER_BYTES = 1'b0;
  localparam logic REG_NUM_HASHES   = 1'b1;

  localparam logic [12:0] FB_RESET = 13'd4096;
  localparam logic [4:0]  NH_RESET = 5'd3;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_TRD   = 3'd3;
  localparam logic [2:0] ST_TCHK  = 3'd4;
  localparam logic [2:0] ST_SRD   = 3'd5;
  localparam logic [2:0] ST_SWR   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [12:0]       fb_r;
  logic [4:0]        nh_r;
  logic [NBW-1:0]    nb_eff;
  logic [HW-1:0]     nh_eff;
  logic [MW-1:0]     m_val;
  logic [MW-1:0]     m_r;
  logic [MW-1:0]     acc_r;
  logic [MW-1:0]     inc_r;
  logic [HW-1:0]     i_r;
  logic [HW-1:0]     i_inc;
  logic              query_r;
  logic              present_r;
  logic              out_valid_r;
  logic              out_was_present_r;
  logic              out_is_query_r;
  logic              in_fire;
  logic              key_end;
  logic              last_pos;
  logic              cfg_wr;
  logic [HASH_W-1:0] djb2_val;
  logic [HASH_W-1:0] sdbm_val;
  mod_sts_t          d_sts;
  mod_sts_t          s_sts;
  mod_sts_t          w_sts;
  logic [MW-1:0]     d_res;
  logic [MW-1:0]     s_res;
  logic [MW-1:0]     w_res;
  store_ctl_t        st_ctl;
  logic [7:0]        st_rdata;
  logic [7:0]        st_wdata;
  logic              clear_busy;
  logic [MW:0]       sum_a, sum_b, sum_c;
  logic [MW-1:0]     red_a, acc_nxt, inc_nxt;
  logic [HASH_W-1:0] djb2_full_r;
  logic [HASH_W-1:0] sdbm_full_r;
  logic [HASH_W-1:0] pos_r;
  logic [HASH_W+1:0] pos_sum;
  logic [MW:0]       wrap_one, wrap2_sum, off_diff;
  logic [MW-1:0]     wrap_val, wrap_r, wrap2, wrap_sel;
  logic [MW-1:0]     off_r, off_nxt;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= FB_RESET;
      nh_r <= NH_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FILTER_BYTES: fb_r <= pwdata[12:0];
        REG_NUM_HASHES:   nh_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FILTER_BYTES: prdata = {19'd0, fb_r};
      REG_NUM_HASHES:   prdata = {27'd0, nh_r};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (fb_r == '0)                      nb_eff = NBW'(1);
    else if (32'(fb_r) > 32'(MAX_BYTES)) nb_eff = NBW'(MAX_BYTES);
    else                                 nb_eff = NBW'(fb_r);
    if (nh_r == '0)                       nh_eff = HW'(1);
    else if (32'(nh_r) > 32'(MAX_HASHES)) nh_eff = HW'(MAX_HASHES);
    else                                  nh_eff = HW'(nh_r);
  end

  // position p mod 8*nb: byte index is the upper part, bit the low 3 bits
  assign m_val = {nb_eff, 3'b000};

  // ---------------- hashing ----------------
  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign key_end  = in_fire && in_last_byte;

  bfdh_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .key_byte  (in_key_byte),
    .last_byte (in_last_byte),
    .djb2_val  (djb2_val),
    .sdbm_val  (sdbm_val)
  );

  bfdh_mod #(.MW(MW)) u_mod_djb2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (key_end),
    .value   (djb2_val),
    .modulus (m_val),
    .sts     (d_sts),
    .result  (d_res)
  );

  bfdh_mod #(.MW(MW)) u_mod_sdbm (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (key_end),
    .value   (sdbm_val),
    .modulus (m_val),
    .sts     (s_sts),
    .result  (s_res)
  );

  // (2^64 - 1) mod m, one step short of 2^64 mod m
  bfdh_mod #(.MW(MW)) u_mod_wrap (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (key_end),
    .value   ({HASH_W{1'b1}}),
    .modulus (m_val),
    .sts     (w_sts),
    .result  (w_res)
  );

  // ---------------- position walk ----------------
  assign wrap_one  = {1'b0, w_res} + (MW+1)'(1);
  assign wrap_val  = (wrap_one == {1'b0, m_r}) ? '0 : MW'(wrap_one);
  assign wrap2_sum = {1'b0, wrap_r} + {1'b0, wrap_r};
  assign wrap2     = (wrap2_sum >= {1'b0, m_r}) ? MW'(wrap2_sum - {1'b0, m_r})
                                                : MW'(wrap2_sum);

  // full 64-bit step; each carry out drops 2^64 from the true position
  assign pos_sum = {2'b00, pos_r} + {2'b00, sdbm_full_r} + (HASH_W+2)'({i_r, 1'b1});

  always_comb begin
    case (pos_sum[HASH_W+1:HASH_W])
      2'd0:    wrap_sel = '0;
      2'd1:    wrap_sel = wrap_r;
      default: wrap_sel = wrap2;
    endcase
  end

  assign off_diff = {1'b0, inc_r} + {1'b0, m_r} - {1'b0, wrap_sel};
  assign off_nxt  = (inc_r >= wrap_sel) ? (inc_r - wrap_sel) : MW'(off_diff);

  // p(i+1) = p(i) + sdbm + (2i+1) - carry*2^64, all kept reduced mod m
  assign sum_a   = {1'b0, acc_r} + {1'b0, s_res};
  assign red_a   = (sum_a >= {1'b0, m_r}) ? MW'(sum_a - {1'b0, m_r}) : MW'(sum_a);
  assign sum_b   = {1'b0, red_a} + {1'b0, off_r};
  assign acc_nxt = (sum_b >= {1'b0, m_r}) ? MW'(sum_b - {1'b0, m_r}) : MW'(sum_b);
  assign sum_c   = {1'b0, inc_r} + (MW+1)'(2);
  assign inc_nxt = (sum_c >= {1'b0, m_r}) ? MW'(sum_c - {1'b0, m_r}) : MW'(sum_c);

  assign i_inc    = i_r + 1'b1;
  assign last_pos = (i_inc == nh_eff);

  assign st_ctl.rd_en = (state_r == ST_TRD) || (state_r == ST_SRD);
  assign st_ctl.wr_en = (state_r == ST_SWR);
  assign st_wdata     = st_rdata | (8'd1 << acc_r[2:0]);

  bfdh_store #(.DEPTH(MAX_BYTES), .AW(AW)) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (st_ctl),
    .addr       (acc_r[AW+2:3]),
    .wdata      (st_wdata),
    .rdata      (st_rdata),
    .clear_busy (clear_busy)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (!clear_busy) state_nxt = ST_IDLE;
      ST_IDLE:  if (key_end) state_nxt = ST_MOD;
      ST_MOD:   if (d_sts.done && s_sts.done && w_sts.done) state_nxt = ST_TRD;
      ST_TRD:   state_nxt = ST_TCHK;
      ST_TCHK: begin
        if (!last_pos)    state_nxt = ST_TRD;
        else if (query_r) state_nxt = ST_DONE;
        else              state_nxt = ST_SRD;
      end
      ST_SRD:   state_nxt = ST_SWR;
      ST_SWR:   state_nxt = last_pos ? ST_DONE : ST_SRD;
      ST_DONE:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      i_r       <= '0;
      present_r <= 1'b1;
      query_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (key_end) query_r <= in_req_type;
      case (state_r)
        ST_MOD: begin
          i_r       <= '0;
          present_r <= 1'b1;
        end
        ST_TCHK: begin
          present_r <= present_r & st_rdata[acc_r[2:0]];
          i_r       <= last_pos ? '0 : i_inc;
        end
        ST_SWR:  i_r <= i_inc;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (key_end) begin
      m_r         <= m_val;
      djb2_full_r <= djb2_val;
      sdbm_full_r <= sdbm_val;
    end
    case (state_r)
      ST_MOD: begin
        acc_r  <= d_res;
        inc_r  <= MW'(1);
        pos_r  <= djb2_full_r;
        wrap_r <= wrap_val;
      end
      ST_TRD, ST_SRD: begin
        off_r <= off_nxt;
        pos_r <= pos_sum[HASH_W-1:0];
      end
      ST_TCHK: begin
        if (last_pos) begin
          // second pass sets the bits from the first position again
          acc_r <= d_res;
          inc_r <= MW'(1);
          pos_r <= djb2_full_r;
        end else begin
          acc_r <= acc_nxt;
          inc_r <= inc_nxt;
        end
      end
      ST_SWR: begin
        acc_r <= acc_nxt;
        inc_r <= inc_nxt;
      end
      default: ;
    endcase
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_was_present_r <= present_r;
      out_is_query_r    <= query_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_was_present = out_was_present_r;
  assign out_is_query    = out_is_query_r;

  // ---------------- assertions ----------------
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> in_stall)
    else $error("byte taken during store clear");

  a_store_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
    st_ctl.wr_en |-> (!query_r && !clear_busy))
    else $error("store written outside an insert");

  a_pos_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TRD || state_r == ST_SRD) |-> (acc_r < m_r && inc_r < m_r))
    else $error("position not reduced modulo store size");

  a_mod_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD) |-> ((d_sts == s_sts) && (d_sts == w_sts)))
    else $error("hash reduction units out of step");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |=> (!out_valid_r || $past(state_r) == ST_DONE))
    else $error("result raised outside done state");

endmodule
